@@ rtl/brmt_pkg.sv @@
// ----------------------------------------------------------------------------
// brmt_pkg
// Shared types, codes and helpers of the budgeted multi-channel release timer.
// ----------------------------------------------------------------------------
package brmt_pkg;

  localparam int CHANNELS = 2;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SEC_W    = 16;
  localparam int PER_W    = 14;
  localparam int CFG_CH   = 2;

  localparam int PULSE_AT_ZERO = 500;
  localparam int PULSE_AT_HOUR = 5000;
  localparam int HOUR_SECONDS  = 3600;
  localparam int PULSE_MIN     = 250;
  localparam int PULSE_MAX     = 10000;

  // 4500/3600 reduces to 5/4, so the scaling is a small multiply and a shift
  localparam int PULSE_GCD   = 900;
  localparam int PULSE_NUM   = (PULSE_AT_HOUR - PULSE_AT_ZERO) / PULSE_GCD;
  localparam int PULSE_DEN   = HOUR_SECONDS / PULSE_GCD;
  localparam int PULSE_SHIFT = $clog2(PULSE_DEN);
  localparam int PRAW_W      = SEC_W + 3;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ARM     = 3'd1,
    CMD_HOLD    = 3'd2,
    CMD_START   = 3'd3,
    CMD_ADD     = 3'd4,
    CMD_RELEASE = 3'd5,
    CMD_QUERY   = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_ARMED    = 3'd1,
    ST_HOLDING  = 3'd2,
    ST_ACTIVE   = 3'd3,
    ST_RELEASED = 3'd4
  } chan_st_t;

  typedef enum logic [1:0] {
    REG_CH0_DEFAULT = 2'd0,
    REG_CH0_LIMIT   = 2'd1,
    REG_CH1_DEFAULT = 2'd2,
    REG_CH1_LIMIT   = 2'd3
  } reg_idx_t;

  localparam logic [SEC_W-1:0] CH0_DEFAULT_RST = 16'd3600;
  localparam logic [SEC_W-1:0] CH0_LIMIT_RST   = 16'd3600;
  localparam logic [SEC_W-1:0] CH1_DEFAULT_RST = 16'd3600;
  localparam logic [SEC_W-1:0] CH1_LIMIT_RST   = 16'd7200;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } brmt_cmd_t;

  // budget left: limit minus elapsed, floored at zero
  function automatic logic [SEC_W-1:0] avail_of(input logic [SEC_W-1:0] elapsed,
                                                input logic [SEC_W-1:0] limit);
    avail_of = (elapsed >= limit) ? '0 : limit - elapsed;
  endfunction

endpackage

@@ rtl/brmt_ctrl.sv @@
// ----------------------------------------------------------------------------
// brmt_ctrl
// Sequencer: accept an item, update channel state, then form the result.
// ----------------------------------------------------------------------------
module brmt_ctrl
  import brmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output brmt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SUM  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/brmt_datapath.sv @@
// ----------------------------------------------------------------------------
// brmt_datapath
// Configuration, per-channel timer state and the result register.
// ----------------------------------------------------------------------------
module brmt_datapath
  import brmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  brmt_cmd_t         cmd,
  input  logic [2:0]        in_command,
  input  logic              in_channel,
  input  logic [SEC_W-1:0]  in_seconds,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [SEC_W-1:0]  cfg_data,
  output logic              out_ok,
  output logic [2:0]        out_chan_status,
  output logic [SEC_W-1:0]  out_chan_remaining,
  output logic [SEC_W-1:0]  out_chan_available,
  output logic              out_chan_running,
  output logic [1:0]        out_released_mask,
  output logic [SEC_W-1:0]  out_longest_remaining,
  output logic [PER_W-1:0]  out_pulse_period_ms
);

  logic [SEC_W-1:0] def_r [CFG_CH];
  logic [SEC_W-1:0] lim_r [CFG_CH];

  cmd_t             cmd_r;
  logic [CH_W-1:0]  chan_r;
  logic [SEC_W-1:0] secs_r;

  chan_st_t         st_r   [CHANNELS];
  chan_st_t         st_nxt [CHANNELS];
  logic             run_r  [CHANNELS];
  logic             run_nxt[CHANNELS];
  logic [SEC_W-1:0] el_r   [CHANNELS];
  logic [SEC_W-1:0] el_nxt [CHANNELS];
  logic [SEC_W-1:0] left_r [CHANNELS];
  logic [SEC_W-1:0] left_nxt[CHANNELS];

  logic                ok_r, ok_nxt;
  logic [CHANNELS-1:0] mask_r, mask_nxt;

  logic [SEC_W-1:0]  longest;
  logic [PRAW_W-1:0] period_raw;
  logic [PRAW_W-1:0] period;
  logic [CH_W-1:0]   chan_sel;

  // channel indexes at or above the channel count address the last channel
  assign chan_sel = (32'(in_channel) >= CHANNELS) ? CH_W'(CHANNELS - 1) : CH_W'(in_channel);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= cmd_t'(in_command);
      chan_r <= chan_sel;
      secs_r <= in_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_r[0] <= CH0_DEFAULT_RST;
      lim_r[0] <= CH0_LIMIT_RST;
      def_r[1] <= CH1_DEFAULT_RST;
      lim_r[1] <= CH1_LIMIT_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CH0_DEFAULT: def_r[0] <= cfg_data;
        REG_CH0_LIMIT:   lim_r[0] <= cfg_data;
        REG_CH1_DEFAULT: def_r[1] <= cfg_data;
        REG_CH1_LIMIT:   lim_r[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [SEC_W-1:0] avail;
    logic [SEC_W:0]   sum;
    ok_nxt   = 1'b1;
    mask_nxt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      st_nxt[i]   = st_r[i];
      run_nxt[i]  = run_r[i];
      el_nxt[i]   = el_r[i];
      left_nxt[i] = left_r[i];
      avail = avail_of(el_r[i], lim_r[i]);
      sum   = {1'b0, secs_r} + {1'b0, left_r[i]};
      if (cmd_r == CMD_TICK) begin
        if (run_r[i] && (left_r[i] != '0) && (el_r[i] < lim_r[i])) begin
          el_nxt[i]   = el_r[i] + 1'b1;
          left_nxt[i] = left_r[i] - 1'b1;
          if (left_r[i] == SEC_W'(1)) begin
            run_nxt[i]  = 1'b0;
            st_nxt[i]   = ST_RELEASED;
            mask_nxt[i] = 1'b1;
          end
        end
      end else if (32'(chan_r) == i) begin
        case (cmd_r)
          CMD_ARM: begin
            run_nxt[i]  = 1'b1;
            el_nxt[i]   = '0;
            left_nxt[i] = def_r[i];
            st_nxt[i]   = ST_ARMED;
          end
          CMD_HOLD, CMD_START: begin
            if (st_r[i] inside {ST_ARMED, ST_HOLDING}) begin
              if (cmd_r == CMD_HOLD) begin
                el_nxt[i]   = '0;
                left_nxt[i] = def_r[i];
                st_nxt[i]   = ST_HOLDING;
              end else begin
                left_nxt[i] = (secs_r < avail) ? secs_r : avail;
                st_nxt[i]   = ST_ACTIVE;
              end
            end else begin
              // refused: drop the channel back to idle
              st_nxt[i]   = ST_IDLE;
              run_nxt[i]  = 1'b0;
              el_nxt[i]   = '0;
              left_nxt[i] = '0;
              ok_nxt      = 1'b0;
            end
          end
          CMD_ADD: begin
            left_nxt[i] = (sum < {1'b0, avail}) ? sum[SEC_W-1:0] : avail;
          end
          CMD_RELEASE: begin
            st_nxt[i]   = ST_IDLE;
            run_nxt[i]  = 1'b0;
            el_nxt[i]   = '0;
            left_nxt[i] = '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i]   <= ST_IDLE;
        run_r[i]  <= 1'b0;
        el_r[i]   <= '0;
        left_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i]   <= st_nxt[i];
        run_r[i]  <= run_nxt[i];
        el_r[i]   <= el_nxt[i];
        left_r[i] <= left_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r   <= ok_nxt;
      mask_r <= mask_nxt;
    end
  end

  always_comb begin
    longest = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (left_r[i] > longest) begin
        longest = left_r[i];
      end
    end
  end

  assign period_raw = PRAW_W'(PULSE_AT_ZERO)
                    + ((PRAW_W'(PULSE_NUM) * {3'b000, longest}) >> PULSE_SHIFT);

  always_comb begin
    if (period_raw < PRAW_W'(PULSE_MIN)) begin
      period = PRAW_W'(PULSE_MIN);
    end else if (period_raw > PRAW_W'(PULSE_MAX)) begin
      period = PRAW_W'(PULSE_MAX);
    end else begin
      period = period_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ok                <= ok_r;
      out_chan_status       <= st_r[chan_r];
      out_chan_remaining    <= left_r[chan_r];
      out_chan_available    <= avail_of(el_r[chan_r], lim_r[chan_r]);
      out_chan_running      <= run_r[chan_r];
      out_released_mask     <= 2'(mask_r);
      out_longest_remaining <= longest;
      out_pulse_period_ms   <= period[PER_W-1:0];
    end
  end

endmodule

@@ rtl/budgeted_multi_channel_release_timer.sv @@
// ----------------------------------------------------------------------------
// budgeted_multi_channel_release_timer
// Two-channel countdown timer with per-channel time budgets and LED period.
// ----------------------------------------------------------------------------
// Each item passes through the sequencer states in order: it is accepted and
// captured, then every channel's state is updated, then the longest remaining
// time, the pulse period and the addressed channel's status are formed and
// loaded into the output register. The sequencer takes one item at a time, so
// a new item is not accepted until the previous one has been loaded. An item
// may be accepted while the previous result still waits on a stalled output.
// The result stage then waits for the output register to empty.
// Configuration writes apply at once and must come only while no item is in
// flight.
module budgeted_multi_channel_release_timer
  import brmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_command,
  input  logic              in_channel,
  input  logic [SEC_W-1:0]  in_seconds,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_ok,
  output logic [2:0]        out_chan_status,
  output logic [SEC_W-1:0]  out_chan_remaining,
  output logic [SEC_W-1:0]  out_chan_available,
  output logic              out_chan_running,
  output logic [1:0]        out_released_mask,
  output logic [SEC_W-1:0]  out_longest_remaining,
  output logic [PER_W-1:0]  out_pulse_period_ms,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [SEC_W-1:0]  cfg_data
);

  brmt_cmd_t cmd;

  brmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  brmt_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_command            (in_command),
    .in_channel            (in_channel),
    .in_seconds            (in_seconds),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_ok                (out_ok),
    .out_chan_status       (out_chan_status),
    .out_chan_remaining    (out_chan_remaining),
    .out_chan_available    (out_chan_available),
    .out_chan_running      (out_chan_running),
    .out_released_mask     (out_released_mask),
    .out_longest_remaining (out_longest_remaining),
    .out_pulse_period_ms   (out_pulse_period_ms)
  );

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another is in flight");

  a_longest_covers_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_longest_remaining >= out_chan_remaining)
    else $error("longest remaining below addressed channel remaining");

  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pulse_period_ms >= 14'd250) && (out_pulse_period_ms <= 14'd10000))
    else $error("pulse period out of clamp range");

  a_mask_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_released_mask != 2'b00) |-> out_ok)
    else $error("release reported with a refused item");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the budgeted two-channel release timer: drives
// command items under random idling on both sides, predicts every result
// from a cycle-free model of the channels and compares it field by field.
// ----------------------------------------------------------------------------
module tb
  import brmt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE  = 3'd7;   // unused code, behaves as query
  localparam int         IDLE_LIMIT = 20000;  // cycles without any handshake
  localparam int         PHASES     = 6;
  localparam int         PHASE_ITEMS = 305;

  typedef struct packed {
    logic             ok;
    logic [2:0]       status;
    logic [SEC_W-1:0] remaining;
    logic [SEC_W-1:0] available;
    logic             running;
    logic [1:0]       mask;
    logic [SEC_W-1:0] longest;
    logic [PER_W-1:0] period;
  } timer_res_t;

  class timer_scoreboard;
    chan_st_t         st      [CHANNELS];
    bit               run     [CHANNELS];
    logic [SEC_W-1:0] elapsed [CHANNELS];
    logic [SEC_W-1:0] left_s  [CHANNELS];
    logic [SEC_W-1:0] dflt    [CHANNELS];
    logic [SEC_W-1:0] limit   [CHANNELS];
    timer_res_t       expected_q[$];
    int               errors;
    int               results;

    function new();
      for (int i = 0; i < CHANNELS; i++) begin
        clear_chan(i);
      end
      dflt[0]  = CH0_DEFAULT_RST;
      limit[0] = CH0_LIMIT_RST;
      dflt[1]  = CH1_DEFAULT_RST;
      limit[1] = CH1_LIMIT_RST;
      errors   = 0;
      results  = 0;
    endfunction

    function void clear_chan(int c);
      st[c]      = ST_IDLE;
      run[c]     = 1'b0;
      elapsed[c] = '0;
      left_s[c]  = '0;
    endfunction

    function logic [SEC_W-1:0] budget_left(int c);
      return (elapsed[c] >= limit[c]) ? '0 : limit[c] - elapsed[c];
    endfunction

    function void set_register(reg_idx_t idx, logic [SEC_W-1:0] val);
      case (idx)
        REG_CH0_DEFAULT: dflt[0]  = val;
        REG_CH0_LIMIT:   limit[0] = val;
        REG_CH1_DEFAULT: dflt[1]  = val;
        default:         limit[1] = val;
      endcase
    endfunction

    // advance the channel model by one item and queue the result it causes
    function void note_input(logic [2:0] cmd, logic ch, logic [SEC_W-1:0] secs);
      timer_res_t  res;
      int          c;
      int unsigned sum;
      int unsigned cap;
      int unsigned longest;
      int unsigned per;
      c        = int'(ch);
      res      = '0;
      res.ok   = 1'b1;
      case (cmd)
        CMD_TICK: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (run[i] && left_s[i] != 0 && elapsed[i] < limit[i]) begin
              elapsed[i] = elapsed[i] + 1'b1;
              left_s[i]  = left_s[i] - 1'b1;
              if (left_s[i] == 0) begin
                run[i]      = 1'b0;
                st[i]       = ST_RELEASED;
                res.mask[i] = 1'b1;
              end
            end
          end
        end
        CMD_ARM: begin
          run[c]     = 1'b1;
          elapsed[c] = '0;
          left_s[c]  = dflt[c];
          st[c]      = ST_ARMED;
        end
        CMD_HOLD, CMD_START: begin
          if (st[c] == ST_ARMED || st[c] == ST_HOLDING) begin
            if (cmd == CMD_HOLD) begin
              elapsed[c] = '0;
              left_s[c]  = dflt[c];
              st[c]      = ST_HOLDING;
            end else begin
              cap       = budget_left(c);
              left_s[c] = (secs < cap) ? secs : SEC_W'(cap);
              st[c]     = ST_ACTIVE;
            end
          end else begin
            clear_chan(c);
            res.ok = 1'b0;
          end
        end
        CMD_ADD: begin
          cap       = budget_left(c);
          sum       = int'(secs) + int'(left_s[c]);
          left_s[c] = (sum < cap) ? SEC_W'(sum) : SEC_W'(cap);
        end
        CMD_RELEASE: clear_chan(c);
        default: ;
      endcase
      longest = 0;
      for (int i = 0; i < CHANNELS; i++) begin
        if (left_s[i] > longest) longest = left_s[i];
      end
      per = PULSE_AT_ZERO + ((PULSE_AT_HOUR - PULSE_AT_ZERO) * longest) / HOUR_SECONDS;
      if (per < PULSE_MIN) per = PULSE_MIN;
      if (per > PULSE_MAX) per = PULSE_MAX;
      res.status    = st[c];
      res.remaining = left_s[c];
      res.available = budget_left(c);
      res.running   = run[c];
      res.longest   = SEC_W'(longest);
      res.period    = PER_W'(per);
      expected_q.push_back(res);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] result %0d:%s", $time, results, msg);
    endfunction

    function void check_result(timer_res_t got);
      timer_res_t exp;
      string      diffs;
      results++;
      if (expected_q.size() == 0) begin
        report(" result arrived with nothing expected");
        return;
      end
      exp   = expected_q.pop_front();
      diffs = "";
      if (got.ok !== exp.ok)
        diffs = {diffs, $sformatf(" ok exp %0d got %0d", exp.ok, got.ok)};
      if (got.status !== exp.status)
        diffs = {diffs, $sformatf(" status exp %0d got %0d", exp.status, got.status)};
      if (got.remaining !== exp.remaining)
        diffs = {diffs, $sformatf(" remaining exp %0d got %0d", exp.remaining, got.remaining)};
      if (got.available !== exp.available)
        diffs = {diffs, $sformatf(" available exp %0d got %0d", exp.available, got.available)};
      if (got.running !== exp.running)
        diffs = {diffs, $sformatf(" running exp %0d got %0d", exp.running, got.running)};
      if (got.mask !== exp.mask)
        diffs = {diffs, $sformatf(" mask exp %0d got %0d", exp.mask, got.mask)};
      if (got.longest !== exp.longest)
        diffs = {diffs, $sformatf(" longest exp %0d got %0d", exp.longest, got.longest)};
      if (got.period !== exp.period)
        diffs = {diffs, $sformatf(" period exp %0d got %0d", exp.period, got.period)};
      if (diffs != "") report(diffs);
    endfunction

    function void flag_leftovers();
      if (expected_q.size() != 0)
        report($sformatf(" %0d results never arrived", expected_q.size()));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       in_command = CMD_QUERY;
  logic             in_channel = 1'b0;
  logic [SEC_W-1:0] in_seconds = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_ok;
  logic [2:0]       out_chan_status;
  logic [SEC_W-1:0] out_chan_remaining;
  logic [SEC_W-1:0] out_chan_available;
  logic             out_chan_running;
  logic [1:0]       out_released_mask;
  logic [SEC_W-1:0] out_longest_remaining;
  logic [PER_W-1:0] out_pulse_period_ms;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [SEC_W-1:0] cfg_data = '0;

  timer_scoreboard sb;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              quiet_cycles = 0;

  budgeted_multi_channel_release_timer i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_channel            (in_channel),
    .in_seconds            (in_seconds),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_ok                (out_ok),
    .out_chan_status       (out_chan_status),
    .out_chan_remaining    (out_chan_remaining),
    .out_chan_available    (out_chan_available),
    .out_chan_running      (out_chan_running),
    .out_released_mask     (out_released_mask),
    .out_longest_remaining (out_longest_remaining),
    .out_pulse_period_ms   (out_pulse_period_ms),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_ok, out_chan_status, out_chan_remaining, out_chan_available,
                       out_chan_running, out_released_mask, out_longest_remaining,
                       out_pulse_period_ms});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mostly short requests so that channels actually run down to release
  function automatic logic [SEC_W-1:0] pick_seconds();
    if ($urandom_range(3) != 0) return SEC_W'($urandom_range(20));
    return SEC_W'($urandom);
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic ch,
                           input logic [SEC_W-1:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_channel <= ch;
    in_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, ch, secs);
  endtask

  // hold off the sender until every queued result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic put_register(input reg_idx_t idx, input logic [SEC_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task automatic apply_settings(input logic [SEC_W-1:0] d0, input logic [SEC_W-1:0] l0,
                                input logic [SEC_W-1:0] d1, input logic [SEC_W-1:0] l1);
    put_register(REG_CH0_DEFAULT, d0);
    put_register(REG_CH0_LIMIT,   l0);
    put_register(REG_CH1_DEFAULT, d1);
    put_register(REG_CH1_LIMIT,   l1);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int c;
    int k;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      c = $urandom_range(1);
      if (r < 70) begin
        // well-formed arm, optional hold, start, countdown
        send_item(CMD_ARM, 1'(c), SEC_W'($urandom));
        sent++;
        k = $urandom_range(2);
        for (int j = 0; j < k; j++) begin
          send_item(CMD_HOLD, 1'(c), SEC_W'($urandom));
          sent++;
        end
        send_item(CMD_START, 1'(c), pick_seconds());
        sent++;
        k = $urandom_range(25);
        for (int j = 0; j < k; j++) begin
          r = $urandom_range(99);
          if (r < 75)      send_item(CMD_TICK, 1'($urandom_range(1)), SEC_W'($urandom));
          else if (r < 85) send_item(CMD_ADD, 1'(c), pick_seconds());
          else if (r < 92) send_item(CMD_QUERY, 1'($urandom_range(1)), SEC_W'($urandom));
          else             send_item(3'($urandom_range(7)), 1'($urandom_range(1)),
                                     pick_seconds());
          sent++;
        end
        if ($urandom_range(3) == 0) begin
          send_item(CMD_RELEASE, 1'(c), SEC_W'($urandom));
          sent++;
        end
      end else begin
        send_item(3'($urandom_range(7)), 1'($urandom_range(1)), pick_seconds());
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 30;
    recv_idle_pct = 56;
    // refused start and hold from idle, spare code, budget caps, release on tick
    send_item(CMD_QUERY,   1'b0, 16'h0000);
    send_item(CMD_SPARE,   1'b1, 16'hFFFF);
    send_item(CMD_TICK,    1'b0, 16'h0000);
    send_item(CMD_START,   1'b0, 16'd10);
    send_item(CMD_HOLD,    1'b1, 16'd0);
    send_item(CMD_ARM,     1'b0, 16'h0000);
    send_item(CMD_HOLD,    1'b0, 16'h0000);
    send_item(CMD_START,   1'b0, 16'hFFFF);
    send_item(CMD_TICK,    1'b0, 16'hFFFF);
    send_item(CMD_ADD,     1'b0, 16'hFFFF);
    send_item(CMD_ARM,     1'b1, 16'd0);
    send_item(CMD_ADD,     1'b1, 16'hFFFF);
    send_item(CMD_START,   1'b1, 16'd0);
    send_item(CMD_TICK,    1'b1, 16'd0);
    send_item(CMD_RELEASE, 1'b1, 16'd0);
    send_item(CMD_ARM,     1'b1, 16'd0);
    send_item(CMD_START,   1'b1, 16'd1);
    send_item(CMD_TICK,    1'b0, 16'd0);
    send_item(CMD_START,   1'b1, 16'd5);
    send_item(CMD_ADD,     1'b1, 16'd0);
    send_item(CMD_HOLD,    1'b0, 16'd0);
    send_item(CMD_RELEASE, 1'b0, 16'd0);
    send_item(CMD_QUERY,   1'b0, 16'd0);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 56;
      end else if (p < 4) begin
        send_idle_pct = 56;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      case (p)
        0: ;
        1: apply_settings(16'd5, 16'd12, 16'd3, 16'd8);
        2: apply_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        4: apply_settings(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        default: apply_settings(SEC_W'($urandom_range(20)), SEC_W'($urandom_range(40)),
                                SEC_W'($urandom_range(20)), SEC_W'($urandom_range(40)));
      endcase
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (10) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
